// ===== rtl/gstft_pkg.sv =====
// shared constants, tables and types for the gaussian window stft
package gstft_pkg;

  localparam int FFT_LEN     = 256;
  localparam int LOG_N       = $clog2(FFT_LEN);
  localparam int ST_BITS     = $clog2(LOG_N);
  localparam int SAMPLE_BITS = 16;
  localparam int WINDOW_BITS = 16;
  localparam int TW_FRAC     = 16;
  localparam int TW_BITS     = TW_FRAC + 2;
  localparam int OUT_BITS    = 25;
  localparam int PROD_BITS   = OUT_BITS + TW_BITS;
  localparam int ACC_BITS    = PROD_BITS + 1;
  localparam int NGROUPS     = FFT_LEN / 4;
  localparam int GROUP_BITS  = 6;
  localparam int CNT_BITS    = 32;
  localparam int FRAME_BITS  = 16;
  localparam int HOP_BITS    = 16;
  localparam int SIGMA       = FFT_LEN / 6;
  localparam logic [HOP_BITS-1:0] HOP_RESET = 16'd64;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [WINDOW_BITS-1:0] win_tab_t [FFT_LEN];
  typedef logic signed [TW_BITS-1:0] tw_tab_t [FFT_LEN/2];

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD,
    S_B_RA, S_B_RB, S_B_M0, S_B_M1, S_B_M2, S_B_M3, S_B_WA, S_B_WB,
    S_O_REQ, S_O_R1, S_O_R2, S_O_R3, S_O_R4, S_O_R5
  } state_t;

  // shift and subtract quotient for table setup
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q, rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic win_tab_t build_win();
    longint unsigned s, den, one, half, num, r, sum, term, w, wmax;
    longint d;
    win_tab_t t;
    s = SIGMA;
    if (s == 0) s = 1;
    den  = 8 * s * s;
    one  = 64'd1 << 31;
    half = 64'd1 << 30;
    wmax = (64'd1 << (WINDOW_BITS - 1)) - 1;
    for (int k = 0; k < FFT_LEN; k++) begin
      d    = 2 * k + 1 - FFT_LEN;
      num  = longint'(d * d);
      r    = udiv((num << 25) + (den >> 1), den);
      sum  = one;
      term = one;
      for (int n = 1; n <= 8; n++) begin
        term = udiv((term * r + half) >> 31, longint'(n));
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      for (int q = 0; q < 6; q++) sum = (sum * sum + half) >> 31;
      w = (sum + (64'd1 << (32 - WINDOW_BITS - 1))) >> (32 - WINDOW_BITS);
      if (w > wmax) w = wmax;
      t[k] = w[WINDOW_BITS-1:0];
    end
    return t;
  endfunction

  function automatic tw_tab_t build_tw(input logic want_im);
    longint unsigned th, th2, tc, ts, half;
    longint c, s, cv, sv;
    longint cq [FFT_LEN/4+1];
    longint sq [FFT_LEN/4+1];
    tw_tab_t t;
    int m;
    half = 64'd1 << 29;
    for (int j = 0; j <= FFT_LEN / 4; j++) begin
      th  = (2 * PI_Q30 * longint'(j) + FFT_LEN / 2) >> LOG_N;
      th2 = (th * th + half) >> 30;
      c   = 64'sd1 << 30;
      s   = longint'(th);
      tc  = 64'd1 << 30;
      ts  = th;
      for (int n = 1; n <= 10; n++) begin
        tc = udiv((tc * th2 + half) >> 30, longint'((2 * n - 1) * (2 * n)));
        ts = udiv((ts * th2 + half) >> 30, longint'((2 * n) * (2 * n + 1)));
        if (n % 2 == 1) begin
          c = c - longint'(tc);
          s = s - longint'(ts);
        end else begin
          c = c + longint'(tc);
          s = s + longint'(ts);
        end
      end
      cq[j] = (c + (64'sd1 <<< (30 - TW_FRAC - 1))) >>> (30 - TW_FRAC);
      sq[j] = (s + (64'sd1 <<< (30 - TW_FRAC - 1))) >>> (30 - TW_FRAC);
    end
    for (int j = 0; j < FFT_LEN / 2; j++) begin
      if (j <= FFT_LEN / 4) begin
        cv = cq[j];
        sv = -sq[j];
      end else begin
        m  = FFT_LEN / 2 - j;
        cv = -cq[m];
        sv = -sq[m];
      end
      t[j] = want_im ? TW_BITS'(sv) : TW_BITS'(cv);
    end
    return t;
  endfunction

  localparam win_tab_t WIN_TAB = build_win();
  localparam tw_tab_t  TW_RE   = build_tw(1'b0);
  localparam tw_tab_t  TW_IM   = build_tw(1'b1);

  function automatic logic [LOG_N-1:0] bit_rev(input logic [LOG_N-1:0] k);
    logic [LOG_N-1:0] r;
    for (int b = 0; b < LOG_N; b++) r[LOG_N-1-b] = k[b];
    return r;
  endfunction

endpackage

// ===== rtl/gstft_ram.sv =====
// generic single write, single read ram with registered read data
module gstft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gaussian_window_stft.sv =====
// top level: streaming gaussian window stft with one shared multiplier
// Takes one sample or pad request at a time and emits each frame as 64 groups of four bins.
// After reset the sample ring is zeroed with in_stall high. A request that does not complete
// a frame is taken without raising in_stall. A request that completes a frame holds in_stall
// through windowing, the 1024 butterflies on the single multiplier and the work memory with
// one write and one read port, and the output groups plus any out_stall time. The last group
// may still wait while the next request enters.
module gaussian_window_stft (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    kind,
  input  logic signed [gstft_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [gstft_pkg::FRAME_BITS-1:0]        frame_index,
  output logic [gstft_pkg::GROUP_BITS-1:0]        group_index,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin0_real,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin0_imag,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin1_real,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin1_imag,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin2_real,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin2_imag,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin3_real,
  output logic signed [gstft_pkg::OUT_BITS-1:0]   bin3_imag,
  output logic                                    frame_end,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [gstft_pkg::HOP_BITS-1:0]          cfg_data
);

  localparam int LOG_N    = gstft_pkg::LOG_N;
  localparam int OB       = gstft_pkg::OUT_BITS;
  localparam int CB       = gstft_pkg::CNT_BITS;
  localparam int ACC_BITS = gstft_pkg::ACC_BITS;
  localparam int RND_BITS = ACC_BITS - gstft_pkg::TW_FRAC;
  localparam int PB       = gstft_pkg::PROD_BITS;
  localparam int TB       = gstft_pkg::TW_BITS;
  localparam logic [gstft_pkg::ST_BITS-1:0] ST_LAST = gstft_pkg::ST_BITS'(LOG_N - 1);

  function automatic logic signed [OB-1:0] sat_out(input logic signed [RND_BITS:0] v);
    logic signed [RND_BITS:0] hi;
    logic signed [RND_BITS:0] lo;
    hi = (RND_BITS+1)'((64'sd1 <<< (OB - 1)) - 1);
    lo = (RND_BITS+1)'(-(64'sd1 <<< (OB - 1)));
    if (v > hi) return hi[OB-1:0];
    if (v < lo) return lo[OB-1:0];
    return v[OB-1:0];
  endfunction

  gstft_pkg::state_t state, state_next;

  logic [gstft_pkg::HOP_BITS-1:0]   hop;
  logic [LOG_N-1:0]                 wp;
  logic [CB-1:0]                    pp, rsc, nfs;
  logic [gstft_pkg::FRAME_BITS-1:0] fe, frame_id;
  logic                             in_padding, done;
  logic [LOG_N-1:0]                 clr;
  logic [LOG_N:0]                   k;
  logic [gstft_pkg::ST_BITS-1:0]    st;
  logic [LOG_N-2:0]                 bf;
  logic [gstft_pkg::GROUP_BITS-1:0] g;
  logic signed [OB-1:0]             ar, ai, br, bi;
  logic signed [ACC_BITS-1:0]       acc;
  logic signed [RND_BITS-1:0]       tr;

  // ring ram
  logic                          ring_we;
  logic [LOG_N-1:0]              ring_waddr, ring_raddr;
  logic [gstft_pkg::SAMPLE_BITS-1:0] ring_wdata, ring_rdata;

  // work ram
  logic                 wk_we;
  logic [LOG_N-1:0]     wk_waddr, wk_raddr;
  logic [2*OB-1:0]      wk_wdata, wk_rdata;
  logic signed [OB-1:0] rd_re, rd_im;

  gstft_ram #(.WIDTH(gstft_pkg::SAMPLE_BITS), .DEPTH(gstft_pkg::FFT_LEN)) u_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .raddr(ring_raddr), .rdata(ring_rdata)
  );

  gstft_ram #(.WIDTH(2*OB), .DEPTH(gstft_pkg::FFT_LEN)) u_work (
    .clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
    .raddr(wk_raddr), .rdata(wk_rdata)
  );

  assign rd_re = $signed(wk_rdata[2*OB-1:OB]);
  assign rd_im = $signed(wk_rdata[OB-1:0]);

  // input request bookkeeping
  logic                accept, pad, early_done, emit;
  logic [CB:0]         rsc_sum, pp_sum, nfs_sum, emit_pos;
  logic [CB-1:0]       rsc_new, pp_new, nfs_new;
  logic [gstft_pkg::HOP_BITS-1:0] hop_eff;
  logic                done_new;

  assign in_stall   = (state != gstft_pkg::S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = in_valid && !in_stall;
  assign pad        = kind || in_padding;
  assign early_done = pad && (nfs > rsc);
  assign rsc_sum    = {1'b0, rsc} + (CB+1)'(1);
  assign rsc_new    = pad ? rsc : (rsc_sum[CB] ? {CB{1'b1}} : rsc_sum[CB-1:0]);
  assign pp_sum     = {1'b0, pp} + (CB+1)'(1);
  assign pp_new     = pp_sum[CB] ? {CB{1'b1}} : pp_sum[CB-1:0];
  assign emit_pos   = {1'b0, nfs} + (CB+1)'(gstft_pkg::FFT_LEN);
  assign emit       = ({1'b0, pp_new} == emit_pos);
  assign hop_eff    = (hop == '0) ? gstft_pkg::HOP_BITS'(1) : hop;
  assign nfs_sum    = {1'b0, nfs} + (CB+1)'(hop_eff);
  assign nfs_new    = emit ? (nfs_sum[CB] ? {CB{1'b1}} : nfs_sum[CB-1:0]) : nfs;
  assign done_new   = pad && (nfs_new > rsc_new);

  // butterfly addressing
  logic [LOG_N-1:0] bf_ext, bmask, blow, bhigh, a_addr, b_addr;
  logic [LOG_N-2:0] tw_idx;
  assign bf_ext = {1'b0, bf};
  assign bmask  = (LOG_N'(1) << st) - LOG_N'(1);
  assign blow   = bf_ext & bmask;
  assign bhigh  = bf_ext >> st;
  assign a_addr = (bhigh << (st + 1'b1)) | blow;
  assign b_addr = a_addr | (LOG_N'(1) << st);
  assign tw_idx = (LOG_N-1)'(blow << (ST_LAST - st));

  logic signed [TB-1:0] wr_tw, wi_tw;
  assign wr_tw = gstft_pkg::TW_RE[tw_idx];
  assign wi_tw = gstft_pkg::TW_IM[tw_idx];

  // shared multiplier
  logic signed [OB-1:0] mul_a;
  logic signed [TB-1:0] mul_b;
  logic signed [PB-1:0] mul_p;
  assign mul_p = PB'(mul_a) * PB'(mul_b);

  logic [LOG_N-1:0]     k_prev;
  logic signed [PB-1:0] win_full;
  logic signed [OB-1:0] win_val;
  assign k_prev   = LOG_N'(k - 1'b1);
  assign win_full = (mul_p + (PB'(1) <<< (gstft_pkg::WINDOW_BITS - 2)))
                    >>> (gstft_pkg::WINDOW_BITS - 1);
  assign win_val  = win_full[OB-1:0];

  logic signed [ACC_BITS-1:0] acc_full;
  logic signed [RND_BITS-1:0] acc_rnd;
  logic signed [OB-1:0]       sum_re, sum_im, dif_re, dif_im;
  assign acc_full = (acc + (ACC_BITS'(1) <<< (gstft_pkg::TW_FRAC - 1))) >>> gstft_pkg::TW_FRAC;
  assign acc_rnd  = acc_full[RND_BITS-1:0];
  assign sum_re   = sat_out((RND_BITS+1)'(ar) + (RND_BITS+1)'(tr));
  assign sum_im   = sat_out((RND_BITS+1)'(ai) + (RND_BITS+1)'(acc_rnd));
  assign dif_re   = sat_out((RND_BITS+1)'(ar) - (RND_BITS+1)'(tr));
  assign dif_im   = sat_out((RND_BITS+1)'(ai) - (RND_BITS+1)'(acc_rnd));

  logic [LOG_N-1:0] grp_base;
  assign grp_base = {g, 2'b00};

  logic bf_last, st_last, g_last;
  assign bf_last = (bf == '1);
  assign st_last = (st == ST_LAST);
  assign g_last  = (g == gstft_pkg::GROUP_BITS'(gstft_pkg::NGROUPS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gstft_pkg::S_CLEAR: if (clr == '1) state_next = gstft_pkg::S_IDLE;
      gstft_pkg::S_IDLE: begin
        if (accept && !done && !early_done && emit) state_next = gstft_pkg::S_LOAD;
      end
      gstft_pkg::S_LOAD: if (k == (LOG_N+1)'(gstft_pkg::FFT_LEN)) state_next = gstft_pkg::S_B_RA;
      gstft_pkg::S_B_RA: state_next = gstft_pkg::S_B_RB;
      gstft_pkg::S_B_RB: state_next = gstft_pkg::S_B_M0;
      gstft_pkg::S_B_M0: state_next = gstft_pkg::S_B_M1;
      gstft_pkg::S_B_M1: state_next = gstft_pkg::S_B_M2;
      gstft_pkg::S_B_M2: state_next = gstft_pkg::S_B_M3;
      gstft_pkg::S_B_M3: state_next = gstft_pkg::S_B_WA;
      gstft_pkg::S_B_WA: state_next = gstft_pkg::S_B_WB;
      gstft_pkg::S_B_WB: begin
        state_next = (bf_last && st_last) ? gstft_pkg::S_O_REQ : gstft_pkg::S_B_RA;
      end
      gstft_pkg::S_O_REQ: if (!out_valid || !out_stall) state_next = gstft_pkg::S_O_R1;
      gstft_pkg::S_O_R1: state_next = gstft_pkg::S_O_R2;
      gstft_pkg::S_O_R2: state_next = gstft_pkg::S_O_R3;
      gstft_pkg::S_O_R3: state_next = gstft_pkg::S_O_R4;
      gstft_pkg::S_O_R4: state_next = gstft_pkg::S_O_R5;
      gstft_pkg::S_O_R5: state_next = g_last ? gstft_pkg::S_IDLE : gstft_pkg::S_O_REQ;
      default: state_next = gstft_pkg::S_IDLE;
    endcase
  end

  // memory and multiplier controls
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = wp;
    ring_wdata = '0;
    ring_raddr = wp + k[LOG_N-1:0];
    wk_we      = 1'b0;
    wk_waddr   = a_addr;
    wk_wdata   = {sum_re, sum_im};
    wk_raddr   = a_addr;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      gstft_pkg::S_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr;
      end
      gstft_pkg::S_IDLE: begin
        ring_we    = accept && !done && !early_done;
        ring_wdata = pad ? '0 : sample;
      end
      gstft_pkg::S_LOAD: begin
        mul_a    = OB'($signed(ring_rdata));
        mul_b    = TB'($signed({1'b0, gstft_pkg::WIN_TAB[k_prev]}));
        wk_we    = (k != '0);
        wk_waddr = gstft_pkg::bit_rev(k_prev);
        wk_wdata = {win_val, {OB{1'b0}}};
      end
      gstft_pkg::S_B_RB: wk_raddr = b_addr;
      gstft_pkg::S_B_M0: begin
        mul_a = rd_re;
        mul_b = wr_tw;
      end
      gstft_pkg::S_B_M1: begin
        mul_a = bi;
        mul_b = wi_tw;
      end
      gstft_pkg::S_B_M2: begin
        mul_a = br;
        mul_b = wi_tw;
      end
      gstft_pkg::S_B_M3: begin
        mul_a = bi;
        mul_b = wr_tw;
      end
      gstft_pkg::S_B_WA: wk_we = 1'b1;
      gstft_pkg::S_B_WB: begin
        wk_we    = 1'b1;
        wk_waddr = b_addr;
        wk_wdata = {dif_re, dif_im};
      end
      gstft_pkg::S_O_R1: wk_raddr = grp_base;
      gstft_pkg::S_O_R2: wk_raddr = grp_base | LOG_N'(1);
      gstft_pkg::S_O_R3: wk_raddr = grp_base | LOG_N'(2);
      gstft_pkg::S_O_R4: wk_raddr = grp_base | LOG_N'(3);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gstft_pkg::S_CLEAR;
      hop        <= gstft_pkg::HOP_RESET;
      wp         <= LOG_N'(gstft_pkg::FFT_LEN / 2);
      pp         <= CB'(gstft_pkg::FFT_LEN / 2);
      rsc        <= '0;
      nfs        <= '0;
      fe         <= '0;
      in_padding <= 1'b0;
      done       <= 1'b0;
      clr        <= '0;
      k          <= '0;
      st         <= '0;
      bf         <= '0;
      g          <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        hop <= cfg_data;
      end
      if (state == gstft_pkg::S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (accept && !done) begin
        in_padding <= pad;
        if (early_done) begin
          done <= 1'b1;
        end else begin
          rsc  <= rsc_new;
          pp   <= pp_new;
          wp   <= wp + 1'b1;
          nfs  <= nfs_new;
          done <= done_new;
          if (emit) begin
            frame_id <= fe;
            fe       <= fe + 1'b1;
            k        <= '0;
          end
        end
      end
      if (state == gstft_pkg::S_LOAD) begin
        k <= k + 1'b1;
        if (k == (LOG_N+1)'(gstft_pkg::FFT_LEN)) begin
          st <= '0;
          bf <= '0;
        end
      end
      if (state == gstft_pkg::S_B_WB) begin
        bf <= bf + 1'b1;
        if (bf_last) begin
          st <= st + 1'b1;
        end
        if (bf_last && st_last) begin
          g <= '0;
        end
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == gstft_pkg::S_O_R5) begin
        out_valid <= 1'b1;
        g         <= g + 1'b1;
      end
    end
  end

  // datapath and output payload
  always_ff @(posedge clk) begin
    case (state)
      gstft_pkg::S_B_RB: begin
        ar <= rd_re;
        ai <= rd_im;
      end
      gstft_pkg::S_B_M0: begin
        br  <= rd_re;
        bi  <= rd_im;
        acc <= ACC_BITS'(mul_p);
      end
      gstft_pkg::S_B_M1: acc <= acc - ACC_BITS'(mul_p);
      gstft_pkg::S_B_M2: begin
        tr  <= acc_rnd;
        acc <= ACC_BITS'(mul_p);
      end
      gstft_pkg::S_B_M3: acc <= acc + ACC_BITS'(mul_p);
      gstft_pkg::S_O_R2: begin
        bin0_real <= rd_re;
        bin0_imag <= rd_im;
      end
      gstft_pkg::S_O_R3: begin
        bin1_real <= rd_re;
        bin1_imag <= rd_im;
      end
      gstft_pkg::S_O_R4: begin
        bin2_real <= rd_re;
        bin2_imag <= rd_im;
      end
      gstft_pkg::S_O_R5: begin
        bin3_real   <= rd_re;
        bin3_imag   <= rd_im;
        group_index <= g;
        frame_index <= frame_id;
        frame_end   <= g_last;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/gstft_checker.sv =====
// port level checks for the gaussian window stft, bound to the top level
module gstft_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [gstft_pkg::FRAME_BITS-1:0]      frame_index,
  input logic [gstft_pkg::GROUP_BITS-1:0]      group_index,
  input logic signed [gstft_pkg::OUT_BITS-1:0] bin0_real,
  input logic                                  frame_end
);

  localparam logic [gstft_pkg::GROUP_BITS-1:0] LAST_GROUP =
    gstft_pkg::GROUP_BITS'(gstft_pkg::NGROUPS - 1);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(bin0_real) && $stable(frame_index))
    else $error("result payload changed while stalled");

  a_end_group: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_end == (group_index == LAST_GROUP)))
    else $error("frame_end does not match last group");

  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |-> in_stall)
    else $error("request taken in the middle of a frame");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall)
    else $error("request taken during ring clear");

endmodule

bind gaussian_window_stft gstft_checker u_checker (.*);
